// File: design/ekf_pkg.sv
// Shared types and constants for the elevation cell Kalman fuse unit.
// Depends on nothing; every other design file but ekf_ram imports it.
`timescale 1ns / 1ps
package ekf_pkg;

    localparam int GRID_ROWS = 256;
    localparam int GRID_COLS = 256;
    localparam int CELLS     = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int PADDR_W   = 5;

    localparam logic [2:0] ACT_INIT    = 3'd0;
    localparam logic [2:0] ACT_IGNORE  = 3'd1;
    localparam logic [2:0] ACT_REPLACE = 3'd2;
    localparam logic [2:0] ACT_NOISE   = 3'd3;
    localparam logic [2:0] ACT_FUSE    = 3'd4;

    localparam int FLAG_VALID = 0;
    localparam int FLAG_TIME  = 1;
    localparam int FLAG_LOW   = 2;

    localparam logic [2:0] REG_MIN_VAR = 3'd0;
    localparam logic [2:0] REG_MAX_VAR = 3'd1;
    localparam logic [2:0] REG_GATE    = 3'd2;
    localparam logic [2:0] REG_NOISE   = 3'd3;
    localparam logic [2:0] REG_WINDOW  = 3'd4;

    localparam logic [31:0] RST_MIN_VAR = 32'd9895605;
    localparam logic [31:0] RST_MAX_VAR = 32'd989560465;
    localparam logic [15:0] RST_GATE    = 16'd6144;
    localparam logic [31:0] RST_NOISE   = 32'd9895605;
    localparam logic [31:0] RST_WINDOW  = 32'd1000;

    typedef struct packed {
        logic [7:0]         cell_row;
        logic [7:0]         cell_col;
        logic signed [31:0] height;
        logic [31:0]        meas_variance;
        logic [23:0]        rgb;
        logic [31:0]        scan_time_ms;
        logic [31:0]        wall_seconds;
        logic signed [31:0] sensor_x;
        logic signed [31:0] sensor_y;
        logic signed [31:0] sensor_z;
    } in_t;

    typedef struct packed {
        logic [7:0]         out_row;
        logic [7:0]         out_col;
        logic [2:0]         action;
        logic signed [31:0] new_height;
        logic [31:0]        new_variance;
        logic               lowest_changed;
    } out_t;

    typedef struct packed {
        logic [31:0] min_variance;
        logic [31:0] max_variance;
        logic [15:0] gate_threshold;
        logic [31:0] multi_height_noise;
        logic [31:0] scan_window_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         flags;
        logic signed [31:0] height;
        logic [31:0]        variance;
        logic [31:0]        scan_time;
        logic [31:0]        wall_time;
        logic [23:0]        rgb;
        logic signed [31:0] lowest;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } cell_t;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_RHS,
        MUL_STEP,
        MUL_VAR
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     cap;
        logic     clr;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     decide;
        logic     div_start;
        logic     sqrt_start;
        logic     wr;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic fuse;
        logic div_done;
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

// File: design/elevation_cell_kalman_fuse_unit.sv
// Top level of the elevation cell Kalman fuse unit: register port, controller, datapath.
// Depends on ekf_pkg, ekf_ctrl and ekf_datapath.
//
// One point beat in, one result beat out per point (points outside the grid give none).
// After reset the cell flags are cleared by a pass over all 65536 cells before the first
// point is taken. A point that initializes, is ignored, replaced or gets noise goes from
// the gate decision straight to the write; a fused point also runs the bit-serial divider
// twice (33 steps each), and the 18-step square root overlaps the first division. A new
// point is taken only once the last one's result is written. A stalled result holds the
// unit until it is taken.
`timescale 1ns / 1ps
module elevation_cell_kalman_fuse_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ekf_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ekf_pkg::out_t                 out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ekf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ekf_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t st;
    logic    [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_variance       <= RST_MIN_VAR;
            cfg_reg.max_variance       <= RST_MAX_VAR;
            cfg_reg.gate_threshold     <= RST_GATE;
            cfg_reg.multi_height_noise <= RST_NOISE;
            cfg_reg.scan_window_ms     <= RST_WINDOW;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_MIN_VAR: cfg_reg.min_variance       <= pwdata;
                REG_MAX_VAR: cfg_reg.max_variance       <= pwdata;
                REG_GATE:    cfg_reg.gate_threshold     <= pwdata[15:0];
                REG_NOISE:   cfg_reg.multi_height_noise <= pwdata;
                REG_WINDOW:  cfg_reg.scan_window_ms     <= pwdata;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_VAR: prdata = cfg_reg.min_variance;
            REG_MAX_VAR: prdata = cfg_reg.max_variance;
            REG_GATE:    prdata = {16'b0, cfg_reg.gate_threshold};
            REG_NOISE:   prdata = cfg_reg.multi_height_noise;
            REG_WINDOW:  prdata = cfg_reg.scan_window_ms;
            default:     prdata = '0;
        endcase
    end

    ekf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    ekf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: design/ekf_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ekf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/ekf_ctrl.sv
// Sequencing state machine for the fuse unit.
// Depends on ekf_pkg for command and status types.
`timescale 1ns / 1ps
module ekf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ekf_pkg::status_t st,
    output ekf_pkg::cmd_t    cmd
);
    import ekf_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WAIT,
        S_MUL_SQ,
        S_MUL_RHS,
        S_DECIDE,
        S_MUL_STEP,
        S_DIV1,
        S_DIV1_WAIT,
        S_MUL_VAR,
        S_DIV2,
        S_DIV2_WAIT,
        S_WRITE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_SQ;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = st.drop ? S_IDLE : S_WAIT;
            end
            S_WAIT:
            begin
                cmd.cap    = 1'b1;
                state_next = S_MUL_SQ;
            end
            S_MUL_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ;
                state_next  = S_MUL_RHS;
            end
            S_MUL_RHS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RHS;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = st.fuse ? S_MUL_STEP : S_WRITE;
            end
            S_MUL_STEP:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_STEP;
                cmd.sqrt_start = 1'b1;
                state_next     = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_MUL_VAR;
                end
            end
            S_MUL_VAR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_VAR;
                state_next  = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (st.out_free)
                begin
                    cmd.wr     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/ekf_datapath.sv
// Cell store, gate, Kalman arithmetic, divider, root unit and output register.
// Depends on ekf_pkg and ekf_ram.
`timescale 1ns / 1ps
module ekf_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  ekf_pkg::cmd_t    cmd,
    output ekf_pkg::status_t st,
    input  ekf_pkg::cfg_t    cfg,
    input  ekf_pkg::in_t     in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output ekf_pkg::out_t    out_data
);
    import ekf_pkg::*;

    function automatic logic [31:0] clamp_var(input logic [32:0] v,
                                              input logic [31:0] lo,
                                              input logic [31:0] hi);
        logic [31:0] r;
        if (v < {1'b0, lo})
            r = lo;
        else if (v > {1'b0, hi})
            r = hi;
        else
            r = v[31:0];
        return r;
    endfunction

    in_t               item_reg;
    cell_t             cell_reg;
    cell_t             ram_rdata;
    cell_t             nrow;
    logic [ADDR_W-1:0] item_addr;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] ram_addr;

    logic [64:0] prod_reg;
    logic [64:0] sq_reg;
    logic [31:0] gg_reg;
    logic [2:0]  act_reg;
    logic [32:0] step_reg;

    logic [32:0] drem_reg;
    logic [32:0] dq_reg;
    logic [5:0]  dcnt_reg;
    logic [35:0] sx_reg;
    logic [18:0] srem_reg;
    logic [17:0] sroot_reg;
    logic [4:0]  scnt_reg;

    logic  out_valid_reg;
    out_t  out_reg;

    always_comb
    begin
        item_addr = ADDR_W'(item_reg.cell_row) * ADDR_W'(GRID_COLS)
                  + ADDR_W'(item_reg.cell_col);
    end

    assign ram_addr = cmd.clr ? clr_addr_reg : item_addr;

    ekf_ram #(
        .WIDTH ($bits(cell_t)),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (cmd.clr | cmd.wr),
        .addr  (ram_addr),
        .wdata (cmd.clr ? '0 : nrow),
        .rdata (ram_rdata)
    );

    // gate arithmetic
    logic signed [32:0] diff;
    logic               neg;
    logic [32:0]        mag;
    logic               outlier;
    logic signed [33:0] tdiff;
    logic               same;
    logic               lower;
    logic [2:0]         act_c;
    logic [32:0]        mul_a;
    logic [32:0]        mul_b;
    logic [65:0]        mul_p;

    always_comb
    begin
        diff    = {item_reg.height[31], item_reg.height} - {cell_reg.height[31], cell_reg.height};
        neg     = diff[32];
        mag     = neg ? 33'(~diff + 33'sd1) : 33'(diff);
        outlier = (sq_reg[64:32] != '0) || ({sq_reg[31:0], 32'b0} > prod_reg[63:0]);
        tdiff   = $signed({2'b00, item_reg.scan_time_ms}) - $signed({2'b00, cell_reg.scan_time});
        same    = cell_reg.flags[FLAG_TIME] && (tdiff <= $signed({2'b00, cfg.scan_window_ms}));
        lower   = cell_reg.height > item_reg.height;
        if (!cell_reg.flags[FLAG_VALID])
            act_c = ACT_INIT;
        else if (outlier && same && lower)
            act_c = ACT_IGNORE;
        else if (outlier && same)
            act_c = ACT_REPLACE;
        else if (outlier)
            act_c = ACT_NOISE;
        else
            act_c = ACT_FUSE;
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SQ:
            begin
                mul_a = mag;
                mul_b = mag;
            end
            MUL_RHS:
            begin
                mul_a = {1'b0, gg_reg};
                mul_b = {1'b0, cell_reg.variance};
            end
            MUL_STEP:
            begin
                mul_a = {1'b0, cell_reg.variance};
                mul_b = mag;
            end
            MUL_VAR:
            begin
                mul_a = {1'b0, cell_reg.variance};
                mul_b = {1'b0, item_reg.meas_variance};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // fusion results
    logic [32:0]        den;
    logic               den_zero;
    logic [33:0]        dtrial;
    logic               dge;
    logic [20:0]        strial;
    logic [20:0]        sr2;
    logic               sge;
    logic signed [32:0] cand_sum;
    logic signed [31:0] cand;
    logic               lowchg;
    logic signed [32:0] fused_h;
    logic [32:0]        noise_sum;

    always_comb
    begin
        den      = {1'b0, cell_reg.variance} + {1'b0, item_reg.meas_variance};
        den_zero = (den == '0);
        dtrial   = {drem_reg, dq_reg[32]};
        dge      = dtrial >= {1'b0, den};
        sr2      = {srem_reg, sx_reg[35:34]};
        strial   = {1'b0, sroot_reg, 2'b01};
        sge      = sr2 >= strial;
        cand_sum = {item_reg.height[31], item_reg.height} + $signed({19'b0, sroot_reg[17:4]});
        cand     = (!cand_sum[32] && cand_sum[31]) ? 32'sh7fffffff : cand_sum[31:0];
        lowchg   = !cell_reg.flags[FLAG_LOW] || (cand < cell_reg.lowest);
        fused_h  = neg ? ({cell_reg.height[31], cell_reg.height} - $signed(step_reg))
                       : ({cell_reg.height[31], cell_reg.height} + $signed(step_reg));
        noise_sum = {1'b0, cell_reg.variance} + {1'b0, cfg.multi_height_noise};
    end

    always_comb
    begin
        nrow = cell_reg;
        case (act_reg)
            ACT_INIT:
            begin
                nrow.height            = item_reg.height;
                nrow.variance          = clamp_var({1'b0, item_reg.meas_variance},
                                                   cfg.min_variance, cfg.max_variance);
                nrow.rgb               = item_reg.rgb;
                nrow.flags[FLAG_VALID] = 1'b1;
            end
            ACT_REPLACE:
            begin
                nrow.height   = item_reg.height;
                nrow.variance = clamp_var({1'b0, item_reg.meas_variance},
                                          cfg.min_variance, cfg.max_variance);
            end
            ACT_NOISE:
            begin
                nrow.variance = clamp_var(noise_sum, cfg.min_variance, cfg.max_variance);
            end
            ACT_FUSE:
            begin
                if (lowchg)
                begin
                    nrow.lowest          = cand;
                    nrow.pos_x           = item_reg.sensor_x;
                    nrow.pos_y           = item_reg.sensor_y;
                    nrow.pos_z           = item_reg.sensor_z;
                    nrow.flags[FLAG_LOW] = 1'b1;
                end
                if (den_zero)
                begin
                    nrow.height   = item_reg.height;
                    nrow.variance = clamp_var('0, cfg.min_variance, cfg.max_variance);
                end
                else
                begin
                    nrow.height   = fused_h[31:0];
                    nrow.variance = clamp_var(dq_reg, cfg.min_variance, cfg.max_variance);
                end
                nrow.rgb              = item_reg.rgb;
                nrow.scan_time        = item_reg.scan_time_ms;
                nrow.wall_time        = item_reg.wall_seconds;
                nrow.flags[FLAG_TIME] = 1'b1;
            end
            default:
            begin
                nrow = cell_reg;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.cap)
        begin
            cell_reg <= ram_rdata;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p[64:0];
        end
        if (cmd.mul_en && cmd.mul_sel == MUL_SQ)
        begin
            gg_reg <= 32'(cfg.gate_threshold * cfg.gate_threshold);
        end
        if (cmd.mul_en && cmd.mul_sel == MUL_RHS)
        begin
            sq_reg <= prod_reg;
        end
        if (cmd.mul_en && cmd.mul_sel == MUL_VAR)
        begin
            step_reg <= dq_reg;
        end
        if (cmd.decide)
        begin
            act_reg <= act_c;
        end
        if (cmd.div_start)
        begin
            drem_reg <= {1'b0, prod_reg[64:33]};
            dq_reg   <= prod_reg[32:0];
        end
        else if (dcnt_reg != '0)
        begin
            drem_reg <= dge ? 33'(dtrial - {1'b0, den}) : dtrial[32:0];
            dq_reg   <= {dq_reg[31:0], dge};
        end
        if (cmd.sqrt_start)
        begin
            sx_reg    <= 36'({4'b0, item_reg.meas_variance} << 3) + {4'b0, item_reg.meas_variance};
            srem_reg  <= '0;
            sroot_reg <= '0;
        end
        else if (scnt_reg != '0)
        begin
            sx_reg    <= {sx_reg[33:0], 2'b00};
            srem_reg  <= sge ? 19'(sr2 - strial) : sr2[18:0];
            sroot_reg <= {sroot_reg[16:0], sge};
        end
        if (cmd.wr)
        begin
            out_reg.out_row        <= item_reg.cell_row;
            out_reg.out_col        <= item_reg.cell_col;
            out_reg.action         <= act_reg;
            out_reg.new_height     <= nrow.height;
            out_reg.new_variance   <= nrow.variance;
            out_reg.lowest_changed <= (act_reg == ACT_FUSE) && lowchg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            dcnt_reg      <= '0;
            scnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.div_start)
            begin
                dcnt_reg <= 6'd33;
            end
            else if (dcnt_reg != '0)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.sqrt_start)
            begin
                scnt_reg <= 5'd18;
            end
            else if (scnt_reg != '0)
            begin
                scnt_reg <= scnt_reg - 1'b1;
            end
            if (cmd.wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        st.drop     = (32'(item_reg.cell_row) >= 32'(GRID_ROWS))
                   || (32'(item_reg.cell_col) >= 32'(GRID_COLS));
        st.fuse     = (act_c == ACT_FUSE);
        st.div_done = (dcnt_reg == '0);
        st.clr_last = (clr_addr_reg == ADDR_W'(CELLS - 1));
        st.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: design/ekf_checker.sv
// Port-level checks for the fuse unit, bound to the top level.
// Depends on ekf_pkg.
`timescale 1ns / 1ps
module ekf_port_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input ekf_pkg::out_t out_data,
    input logic          pready
);
    import ekf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second point taken while one is in flight");

    a_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.action <= ACT_FUSE)
        else $error("action code out of range");

    a_lowest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.lowest_changed |-> out_data.action == ACT_FUSE)
        else $error("lowest point changed outside fusion");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind elevation_cell_kalman_fuse_unit ekf_port_checker u_ekf_checker (.*);
